[design/assert_macros.svh]
// ------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the text screen writer RTL.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// cond never holds
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

[design/tscw_pkg.sv]
// ------------------------------------------------------------------------
// tscw_pkg
// Types and constants of the text screen character writer.
// ------------------------------------------------------------------------
`default_nettype none

package tscw_pkg;

	localparam int DEF_TERMINALS = 4;
	localparam int DEF_COLUMNS   = 80;
	localparam int DEF_ROWS      = 25;

	localparam int CELL_W     = 16;
	localparam int CURSOR_W   = 11;
	localparam int INDEX_W    = 11;
	localparam int CODE_W     = 9;
	localparam int ATTR_W     = 8;
	localparam int TERM_PORT_W = 2;

	// command fields sized for the largest screen and terminal count
	localparam int CMD_TERM_W = 4;
	localparam int CMD_POS_W  = 15;

	localparam int QUEUE_DEPTH = 4;

	localparam int TAB_STOP = 8;
	localparam int TAB_W    = 3;

	localparam logic [CODE_W-1:0] CH_BACKSPACE = 9'h100;
	localparam logic [CODE_W-1:0] CH_BS_ASCII  = 9'h008;
	localparam logic [CODE_W-1:0] CH_TAB       = 9'h009;
	localparam logic [CODE_W-1:0] CH_NEWLINE   = 9'h00A;
	localparam logic [CODE_W-1:0] CH_CR        = 9'h00D;
	localparam logic [CODE_W-1:0] CH_CTRL_LAST = 9'h01F;
	localparam logic [CODE_W-1:0] CH_SPACE     = 9'h020;
	localparam logic [CODE_W-1:0] CH_DELETE    = 9'h07F;
	localparam logic [CODE_W-1:0] CH_IGN_FIRST = 9'h0E2;
	localparam logic [CODE_W-1:0] CH_IGN_LAST  = 9'h0E5;

	localparam logic [7:0] CH_CARET    = 8'h5E;
	localparam logic [7:0] CTRL_OFFSET = 8'h40;

	typedef struct packed {
		logic                  wr0;
		logic                  wr1;
		logic                  rd;
		logic                  scroll;
		logic [CMD_TERM_W-1:0] term;
		logic [CMD_POS_W-1:0]  idx;
		logic [CMD_POS_W-1:0]  base;
		logic [CELL_W-1:0]     data0;
		logic [CELL_W-1:0]     data1;
		logic [CURSOR_W-1:0]   cursor;
	} cmd_t;

endpackage

`default_nettype wire

[design/text_screen_char_writer_top.sv]
// ------------------------------------------------------------------------
// text_screen_char_writer_top
// Per-terminal text screen writer: puts characters at the cursor with
// control code handling and scrolling, and reads back stored cells.
//
//   channel   handshake            payload
//   item in   start / busy         func terminal char_code attribute cell_index
//   result    done (one cycle)     cell_value cursor scrolled
//
// An item that only moves the cursor or stores one cell raises done straight
// from the idle state; a read adds a wait for the registered memory read, a
// caret pair its second cell write, a scroll a clear of the new last row, one
// cell per column (scrolling itself is a row base rotation). After reset busy
// is high while the cells are cleared. The queue holds four items. Results
// cannot be stalled.
// ------------------------------------------------------------------------
`default_nettype none

module text_screen_char_writer_top #(
	parameter int TERMINALS = tscw_pkg::DEF_TERMINALS,
	parameter int COLUMNS   = tscw_pkg::DEF_COLUMNS,
	parameter int ROWS      = tscw_pkg::DEF_ROWS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              func,
	input  wire logic [tscw_pkg::TERM_PORT_W-1:0]  terminal,
	input  wire logic [tscw_pkg::CODE_W-1:0]       char_code,
	input  wire logic [tscw_pkg::ATTR_W-1:0]       attribute,
	input  wire logic [tscw_pkg::INDEX_W-1:0]      cell_index,
	output logic                                   done,
	output logic [tscw_pkg::CELL_W-1:0]            cell_value,
	output logic [tscw_pkg::CURSOR_W-1:0]          cursor,
	output logic                                   scrolled
);
	import tscw_pkg::*;

	localparam int DEPTH  = TERMINALS * ROWS * COLUMNS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t              push_cmd;
	cmd_t              head;
	logic              push;
	logic              pop;
	logic              empty;
	logic              full;
	logic              clearing;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	tscw_front #(
		.TERMINALS (TERMINALS),
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.terminal   (terminal),
		.char_code  (char_code),
		.attribute  (attribute),
		.cell_index (cell_index),
		.clearing   (clearing),
		.q_full     (full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	tscw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	tscw_back #(
		.TERMINALS (TERMINALS),
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.clearing   (clearing),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.done       (done),
		.cell_value (cell_value),
		.cursor     (cursor),
		.scrolled   (scrolled)
	);

	tscw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (DEPTH)
	) u_cells (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

[design/tscw_ram.sv]
// ------------------------------------------------------------------------
// tscw_ram
// Generic single write port RAM with registered read.
// ------------------------------------------------------------------------
`default_nettype none

module tscw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8000,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[design/tscw_queue.sv]
// ------------------------------------------------------------------------
// tscw_queue
// Short command queue between the front and back parts.
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tscw_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire tscw_pkg::cmd_t push_cmd,
	input  wire logic         pop,
	output tscw_pkg::cmd_t    head,
	output logic              empty,
	output logic              full
);
	import tscw_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full && !pop, "queue overflow")
	`ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && empty, "queue underflow")
	`ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1,
		"queue count lost an item")

endmodule

`default_nettype wire

[design/tscw_front.sv]
// ------------------------------------------------------------------------
// tscw_front
// Takes items, decodes the character code, tracks cursor and row base of
// each terminal and issues memory commands to the queue.
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tscw_front #(
	parameter int TERMINALS = 4,
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              func,
	input  wire logic [tscw_pkg::TERM_PORT_W-1:0]  terminal,
	input  wire logic [tscw_pkg::CODE_W-1:0]       char_code,
	input  wire logic [tscw_pkg::ATTR_W-1:0]       attribute,
	input  wire logic [tscw_pkg::INDEX_W-1:0]      cell_index,
	input  wire logic                              clearing,
	input  wire logic                              q_full,
	output logic                                   push,
	output tscw_pkg::cmd_t                         push_cmd
);
	import tscw_pkg::*;

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int POS_W  = $clog2(CELLS + TAB_STOP);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int TERM_W = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

	typedef enum logic [3:0] {
		CL_NEWLINE,
		CL_BACKSPACE,
		CL_TAB,
		CL_CR,
		CL_PRINT,
		CL_DELETE,
		CL_CARET,
		CL_IGNORE,
		CL_OTHER
	} code_class_t;

	logic                   s1_valid_q;
	logic                   s1_func_s1;
	logic [TERM_PORT_W-1:0] s1_term_s1;
	logic [CODE_W-1:0]      s1_code_s1;
	logic [ATTR_W-1:0]      s1_attr_s1;
	logic [INDEX_W-1:0]     s1_idx_s1;

	logic [POS_W-1:0] pos_q  [TERMINALS];
	logic [COL_W-1:0] col_q  [TERMINALS];
	logic [POS_W-1:0] base_q [TERMINALS];

	code_class_t      cls;
	logic [TERM_W-1:0] tidx;
	logic             in_range;
	logic [POS_W-1:0] pos;
	logic [COL_W-1:0] col;
	logic [POS_W-1:0] base;
	logic [3:0]       step;
	logic [COL_W:0]   col_inc;
	logic [POS_W-1:0] pos_n;
	logic [COL_W-1:0] col_n;
	logic [POS_W-1:0] pos_f;
	logic [POS_W-1:0] base_inc;
	logic [POS_W-1:0] base_n;
	logic             scroll;
	logic [7:0]       ch0;
	logic             wr0;
	logic             wr1;
	logic             rd;
	logic             accept;
	logic             upd;

	function automatic logic func_read();
		return s1_func_s1 && (32'(s1_idx_s1) < CELLS);
	endfunction

	assign busy   = clearing || (s1_valid_q && q_full);
	assign accept = start && !busy;
	assign push   = s1_valid_q && !q_full;

	assign tidx     = TERM_W'(s1_term_s1);
	assign in_range = 32'(s1_term_s1) < TERMINALS;
	assign pos      = pos_q[tidx];
	assign col      = col_q[tidx];
	assign base     = base_q[tidx];

	always_comb begin
		priority if (s1_code_s1 == CH_NEWLINE) begin
			cls = CL_NEWLINE;
		end else if (s1_code_s1 == CH_BACKSPACE || s1_code_s1 == CH_BS_ASCII) begin
			cls = CL_BACKSPACE;
		end else if (s1_code_s1 == CH_TAB) begin
			cls = CL_TAB;
		end else if (s1_code_s1 == CH_CR) begin
			cls = CL_CR;
		end else if (s1_code_s1 >= CH_SPACE && s1_code_s1 < CH_DELETE) begin
			cls = CL_PRINT;
		end else if (s1_code_s1 == CH_DELETE) begin
			cls = CL_DELETE;
		end else if (s1_code_s1 <= CH_CTRL_LAST) begin
			cls = CL_CARET;
		end else if (s1_code_s1 >= CH_IGN_FIRST && s1_code_s1 <= CH_IGN_LAST) begin
			cls = CL_IGNORE;
		end else begin
			cls = CL_OTHER;
		end
	end

	always_comb begin
		step    = 4'd0;
		ch0     = s1_code_s1[7:0];
		wr0     = 1'b0;
		wr1     = 1'b0;
		col_inc = '0;
		pos_n   = pos;
		col_n   = col;
		unique case (cls)
			CL_NEWLINE: begin
				pos_n = pos + POS_W'(COLUMNS) - POS_W'(col);
				col_n = '0;
			end
			CL_BACKSPACE: begin
				if (pos != '0) begin
					pos_n = pos - 1'b1;
					col_n = (col == '0) ? COL_W'(COLUMNS - 1) : col - 1'b1;
				end
			end
			CL_CR: begin
				pos_n = pos - POS_W'(col);
				col_n = '0;
			end
			CL_IGNORE: begin
			end
			CL_TAB, CL_PRINT, CL_DELETE, CL_CARET, CL_OTHER: begin
				priority case (cls)
					CL_TAB:   step = 4'(TAB_STOP) - {1'b0, pos[TAB_W-1:0]};
					CL_CARET: step = 4'd2;
					default:  step = 4'd1;
				endcase
				wr0 = (cls != CL_TAB);
				wr1 = (cls == CL_CARET) && (pos + 1'b1 < POS_W'(CELLS));
				if (cls == CL_DELETE) begin
					ch0 = CH_SPACE[7:0];
				end else if (cls == CL_CARET) begin
					ch0 = CH_CARET;
				end
				pos_n   = pos + POS_W'(step);
				col_inc = {1'b0, col} + (COL_W+1)'(step);
				col_n   = (col_inc >= (COL_W+1)'(COLUMNS)) ?
					COL_W'(col_inc - (COL_W+1)'(COLUMNS)) : COL_W'(col_inc);
			end
			default: begin
			end
		endcase
	end

	assign scroll   = pos_n >= POS_W'(CELLS);
	assign pos_f    = scroll ? pos_n - POS_W'(COLUMNS) : pos_n;
	assign base_inc = base + POS_W'(COLUMNS);
	assign base_n   = (base_inc == POS_W'(CELLS)) ? '0 : base_inc;
	assign rd       = in_range && func_read();
	assign upd      = push && in_range && !s1_func_s1;

	always_comb begin
		push_cmd        = '0;
		push_cmd.term   = CMD_TERM_W'(s1_term_s1);
		push_cmd.base   = CMD_POS_W'(base);
		push_cmd.data0  = {s1_attr_s1, ch0};
		push_cmd.data1  = {s1_attr_s1, s1_code_s1[7:0] + CTRL_OFFSET};
		if (in_range) begin
			if (s1_func_s1) begin
				push_cmd.rd     = rd;
				push_cmd.idx    = CMD_POS_W'(s1_idx_s1);
				push_cmd.cursor = CURSOR_W'(pos);
			end else begin
				push_cmd.wr0    = wr0;
				push_cmd.wr1    = wr1;
				push_cmd.scroll = scroll;
				push_cmd.idx    = CMD_POS_W'(pos);
				push_cmd.cursor = CURSOR_W'(pos_f);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_func_s1 <= func;
			s1_term_s1 <= terminal;
			s1_code_s1 <= char_code;
			s1_attr_s1 <= attribute;
			s1_idx_s1  <= cell_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			for (int i = 0; i < TERMINALS; i++) begin
				pos_q[i]  <= '0;
				col_q[i]  <= '0;
				base_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (push) begin
				s1_valid_q <= 1'b0;
			end
			if (upd) begin
				pos_q[tidx] <= pos_f;
				col_q[tidx] <= col_n;
				if (scroll) begin
					base_q[tidx] <= base_n;
				end
			end
		end
	end

	`ASSERT_IMPL(a_cursor_in_screen, clk, arst_n, s1_valid_q && in_range,
		pos < POS_W'(CELLS), "cursor beyond screen")
	`ASSERT_IMPL(a_read_no_scroll, clk, arst_n, push && s1_func_s1,
		!push_cmd.scroll && !push_cmd.wr0, "read item issued a write")
	`ASSERT_NEVER(a_push_needs_item, clk, arst_n, push && !s1_valid_q,
		"push without a decoded item")

endmodule

`default_nettype wire

[design/tscw_back.sv]
// ------------------------------------------------------------------------
// tscw_back
// Executes queued commands on the cell memory: clear after reset, cell
// writes, row clear on scroll, cell reads, and issues the result.
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tscw_back #(
	parameter int TERMINALS = 4,
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	localparam int DEPTH    = TERMINALS * ROWS * COLUMNS,
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tscw_pkg::cmd_t                 head,
	input  wire logic                           empty,
	output logic                                pop,
	output logic                                clearing,
	output logic                                mem_we,
	output logic [ADDR_W-1:0]                   mem_waddr,
	output logic [tscw_pkg::CELL_W-1:0]         mem_wdata,
	output logic [ADDR_W-1:0]                   mem_raddr,
	input  wire logic [tscw_pkg::CELL_W-1:0]    mem_rdata,
	output logic                                done,
	output logic [tscw_pkg::CELL_W-1:0]         cell_value,
	output logic [tscw_pkg::CURSOR_W-1:0]       cursor,
	output logic                                scrolled
);
	import tscw_pkg::*;

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int POS_W  = $clog2(CELLS + TAB_STOP);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int TERM_W = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR1,
		ST_RD,
		ST_ROWCLR
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [COL_W-1:0]  cnt_q;
	cmd_t              cur_q;
	logic              done_q;
	logic [CELL_W-1:0] cell_value_q;
	logic [CURSOR_W-1:0] cursor_q;
	logic              scrolled_q;

	logic [TERM_W-1:0] sel_term;
	logic [POS_W-1:0]  sel_idx;
	logic [POS_W-1:0]  sel_base;
	logic [POS_W:0]    sum;
	logic [POS_W:0]    wrapped;
	logic [ADDR_W-1:0] phys;

	assign clearing   = (state_q == ST_CLEAR);
	assign done       = done_q;
	assign cell_value = cell_value_q;
	assign cursor     = cursor_q;
	assign scrolled   = scrolled_q;

	always_comb begin
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = '0;
		sel_term  = TERM_W'(cur_q.term);
		sel_idx   = POS_W'(cur_q.idx);
		sel_base  = POS_W'(cur_q.base);
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				sel_term  = TERM_W'(head.term);
				sel_idx   = POS_W'(head.idx);
				sel_base  = POS_W'(head.base);
				pop       = !empty;
				mem_we    = !empty && head.wr0;
				mem_wdata = head.data0;
			end
			ST_WR1: begin
				sel_idx   = POS_W'(cur_q.idx) + 1'b1;
				mem_we    = 1'b1;
				mem_wdata = cur_q.data1;
			end
			ST_RD: begin
			end
			ST_ROWCLR: begin
				sel_idx = POS_W'(cnt_q);
				mem_we  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// row base rotation: logical cell plus base, modulo screen size
	assign sum       = {1'b0, sel_idx} + {1'b0, sel_base};
	assign wrapped   = (sum >= (POS_W+1)'(CELLS)) ? sum - (POS_W+1)'(CELLS) : sum;
	assign phys      = ADDR_W'(32'(sel_term) * CELLS) + ADDR_W'(wrapped);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : phys;
	assign mem_raddr = phys;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			cnt_q        <= '0;
			cur_q        <= '0;
			done_q       <= 1'b0;
			cell_value_q <= '0;
			cursor_q     <= '0;
			scrolled_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!empty) begin
						cur_q <= head;
						cnt_q <= '0;
						priority if (head.wr1) begin
							state_q <= ST_WR1;
						end else if (head.scroll) begin
							state_q <= ST_ROWCLR;
						end else if (head.rd) begin
							state_q <= ST_RD;
						end else begin
							done_q       <= 1'b1;
							cell_value_q <= '0;
							cursor_q     <= head.cursor;
							scrolled_q   <= 1'b0;
						end
					end
				end
				ST_WR1: begin
					if (cur_q.scroll) begin
						state_q <= ST_ROWCLR;
					end else begin
						state_q      <= ST_IDLE;
						done_q       <= 1'b1;
						cell_value_q <= '0;
						cursor_q     <= cur_q.cursor;
						scrolled_q   <= 1'b0;
					end
				end
				ST_RD: begin
					state_q      <= ST_IDLE;
					done_q       <= 1'b1;
					cell_value_q <= mem_rdata;
					cursor_q     <= cur_q.cursor;
					scrolled_q   <= 1'b0;
				end
				ST_ROWCLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == COL_W'(COLUMNS - 1)) begin
						state_q      <= ST_IDLE;
						done_q       <= 1'b1;
						cell_value_q <= '0;
						cursor_q     <= cur_q.cursor;
						scrolled_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPL(a_rd_after_pop, clk, arst_n, state_q == ST_RD, $past(pop),
		"read wait without a popped command")
	`ASSERT_IMPL(a_waddr_in_range, clk, arst_n, mem_we, 32'(mem_waddr) < DEPTH,
		"cell write beyond memory")
	`ASSERT_NEVER(a_pop_only_idle, clk, arst_n, pop && state_q != ST_IDLE,
		"command popped while busy")

endmodule

`default_nettype wire
